// ----- hw/rtl/spr_pkg.sv -----
// Shared constants, types and arithmetic helpers for the fixed-point sine pipeline.
package spr_pkg;

    localparam int ANGLE_W         = 48;
    localparam int ANGLE_FRAC_BITS = 32;
    localparam int SINE_W          = 32;
    localparam int NUM_TERMS       = 19;
    localparam int NUM_STEPS       = NUM_TERMS - 1;
    localparam int RED_STAGES      = ANGLE_W / 2;

    typedef logic [63:0] q_t;

    localparam q_t QP       = 64'h1921FB54442D1847;
    localparam q_t TP       = QP * 64'd4;
    localparam q_t STEP     = 64'd1 << (60 - ANGLE_FRAC_BITS);
    localparam q_t ONE_Q62  = 64'd1 << 62;
    localparam q_t HALF_Q32 = 64'd1 << 31;
    localparam logic [32:0] ONE_Q30 = 33'd1 << 30;

    typedef struct packed {
        logic valid;
        logic last;
    } spr_ctl_t;

    typedef struct packed {
        q_t ll;
        q_t lh;
        q_t hl;
        q_t hh;
    } pp_t;

    typedef q_t coef_tab_t [NUM_TERMS];

    // Taylor coefficient magnitudes in Q62, each rounded half up from the previous one
    function automatic coef_tab_t coef_table();
        coef_tab_t t;
        q_t        Den;
        t[0] = ONE_Q62;
        for (int k = 1; k < NUM_TERMS; k++)
        begin
            Den  = 64'((2 * k) * (2 * k + 1));
            t[k] = (t[k-1] + (Den >> 1)) / Den;
        end
        return t;
    endfunction

    localparam coef_tab_t COEF_MAG = coef_table();

    // one bit of the MSB-first reduction modulo 2*pi
    function automatic q_t red_step(q_t r, logic b);
        q_t t;
        t = {r[62:0], 1'b0} + (b ? STEP : 64'd0);
        if (t >= TP)
        begin
            t = t - TP;
        end
        if (t >= TP)
        begin
            t = t - TP;
        end
        return t;
    endfunction

    function automatic pp_t pp_mul(q_t a, q_t b);
        pp_t         p;
        logic [31:0] al;
        logic [31:0] ah;
        logic [31:0] bl;
        logic [31:0] bh;
        al   = a[31:0];
        ah   = a[63:32];
        bl   = b[31:0];
        bh   = b[63:32];
        p.ll = {32'd0, al} * {32'd0, bl};
        p.lh = {32'd0, al} * {32'd0, bh};
        p.hl = {32'd0, ah} * {32'd0, bl};
        p.hh = {32'd0, ah} * {32'd0, bh};
        return p;
    endfunction

    // (a*b) >> 62 from the partial products
    function automatic q_t pp_sum(pp_t p);
        logic [127:0] s;
        s = {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {p.hh, 64'd0};
        return s[125:62];
    endfunction

endpackage

// ----- hw/rtl/spr_in_if.sv -----
// Input channel: angle and batch-end flag with valid/ready handshake.
interface spr_in_if import spr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle;
    logic               last_in;

    modport source (output valid, angle, last_in, input ready);
    modport sink (input valid, angle, last_in, output ready);
endinterface

// ----- hw/rtl/spr_out_if.sv -----
// Output channel: sine result and batch-end flag with valid/ready handshake.
interface spr_out_if import spr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SINE_W-1:0] sine_value;
    logic              last_out;

    modport source (output valid, sine_value, last_out, input ready);
    modport sink (input valid, sine_value, last_out, output ready);
endinterface

// ----- hw/rtl/spr_reduce.sv -----
// Range reduction pipeline: angle modulo 2*pi, quadrant fold to [0, pi/2] in Q62.
module spr_reduce import spr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  spr_ctl_t           ctl_i,
    input  logic [ANGLE_W-1:0] angle,
    output spr_ctl_t           ctl_o,
    output q_t                 x,
    output logic               neg_half
);

    spr_ctl_t           ctl_reg [RED_STAGES+1];
    logic [ANGLE_W-1:0] mag_reg [RED_STAGES+1];
    q_t                 r_reg   [RED_STAGES+1];
    logic               neg_reg [RED_STAGES+1];

    spr_ctl_t ctl_a_reg;
    q_t       r_a_reg;
    spr_ctl_t ctl_f_reg;
    q_t       x_f_reg;
    logic     nh_f_reg;

    q_t r_a_next;
    q_t x_f_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else if (adv)
        begin
            ctl_reg[0] <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg[0] <= angle[ANGLE_W-1] ? (ANGLE_W'(0) - angle) : angle;
            neg_reg[0] <= angle[ANGLE_W-1];
            r_reg[0]   <= '0;
        end
    end

    for (genvar s = 0; s < RED_STAGES; s++)
    begin : g_red
        q_t r_next;
        assign r_next = red_step(red_step(r_reg[s], mag_reg[s][ANGLE_W-1-2*s]),
                                 mag_reg[s][ANGLE_W-2-2*s]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s+1] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mag_reg[s+1] <= mag_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                r_reg[s+1]   <= r_next;
            end
        end
    end

    // negative angles: mirror the remainder
    assign r_a_next = (neg_reg[RED_STAGES] && (r_reg[RED_STAGES] != '0))
                    ? (TP - r_reg[RED_STAGES]) : r_reg[RED_STAGES];

    always_comb
    begin
        if (r_a_reg < QP)
        begin
            x_f_next = r_a_reg;
        end
        else if (r_a_reg < (QP << 1))
        begin
            x_f_next = (QP << 1) - r_a_reg;
        end
        else if (r_a_reg < (QP * 64'd3))
        begin
            x_f_next = r_a_reg - (QP << 1);
        end
        else
        begin
            x_f_next = TP - r_a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_f_reg <= '0;
        end
        else if (adv)
        begin
            ctl_a_reg <= ctl_reg[RED_STAGES];
            ctl_f_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_a_reg  <= r_a_next;
            x_f_reg  <= {x_f_next[61:0], 2'b00};
            nh_f_reg <= (r_a_reg >= (QP << 1));
        end
    end

    assign ctl_o    = ctl_f_reg;
    assign x        = x_f_reg;
    assign neg_half = nh_f_reg;

endmodule

// ----- hw/rtl/spr_horner.sv -----
// Polynomial pipeline: x squared, Horner steps over the odd Taylor series, rounding.
module spr_horner import spr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  spr_ctl_t          ctl_i,
    input  q_t                x,
    input  logic              neg_half,
    output spr_ctl_t          ctl_o,
    output logic [SINE_W-1:0] sine_value
);

    // x squared
    spr_ctl_t xp_ctl_reg;
    pp_t      xp_pp_reg;
    q_t       xp_x_reg;
    logic     xp_nh_reg;

    // accumulator magnitude/sign slots: the initial one and one after each Horner step
    spr_ctl_t a_ctl_reg [NUM_STEPS+1];
    q_t       a_m_reg   [NUM_STEPS+1];
    logic     a_sg_reg  [NUM_STEPS+1];
    q_t       a_x_reg   [NUM_STEPS+1];
    q_t       a_x2_reg  [NUM_STEPS+1];
    logic     a_nh_reg  [NUM_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xp_ctl_reg   <= '0;
            a_ctl_reg[0] <= '0;
        end
        else if (adv)
        begin
            xp_ctl_reg   <= ctl_i;
            a_ctl_reg[0] <= xp_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xp_pp_reg   <= pp_mul(x, x);
            xp_x_reg    <= x;
            xp_nh_reg   <= neg_half;
            a_m_reg[0]  <= COEF_MAG[NUM_TERMS-1];
            a_sg_reg[0] <= ((NUM_TERMS - 1) % 2) == 1;
            a_x_reg[0]  <= xp_x_reg;
            a_x2_reg[0] <= pp_sum(xp_pp_reg);
            a_nh_reg[0] <= xp_nh_reg;
        end
    end

    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_step
        localparam int J = NUM_TERMS - 2 - i;
        localparam logic signed [63:0] C = (J % 2 == 1) ? -$signed(COEF_MAG[J])
                                                        : $signed(COEF_MAG[J]);

        spr_ctl_t            p_ctl_reg;
        pp_t                 p_pp_reg;
        logic                p_sg_reg;
        q_t                  p_x_reg;
        q_t                  p_x2_reg;
        logic                p_nh_reg;
        spr_ctl_t            s_ctl_reg;
        logic signed [63:0]  s_acc_reg;
        q_t                  s_x_reg;
        q_t                  s_x2_reg;
        logic                s_nh_reg;
        logic signed [63:0]  acc_next;
        q_t                  p;

        assign p        = pp_sum(p_pp_reg);
        assign acc_next = p_sg_reg ? (C - $signed(p)) : (C + $signed(p));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p_ctl_reg      <= '0;
                s_ctl_reg      <= '0;
                a_ctl_reg[i+1] <= '0;
            end
            else if (adv)
            begin
                p_ctl_reg      <= a_ctl_reg[i];
                s_ctl_reg      <= p_ctl_reg;
                a_ctl_reg[i+1] <= s_ctl_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p_pp_reg      <= pp_mul(a_m_reg[i], a_x2_reg[i]);
                p_sg_reg      <= a_sg_reg[i];
                p_x_reg       <= a_x_reg[i];
                p_x2_reg      <= a_x2_reg[i];
                p_nh_reg      <= a_nh_reg[i];
                s_acc_reg     <= acc_next;
                s_x_reg       <= p_x_reg;
                s_x2_reg      <= p_x2_reg;
                s_nh_reg      <= p_nh_reg;
                a_m_reg[i+1]  <= s_acc_reg[63] ? (64'd0 - s_acc_reg) : s_acc_reg;
                a_sg_reg[i+1] <= s_acc_reg[63];
                a_x_reg[i+1]  <= s_x_reg;
                a_x2_reg[i+1] <= s_x2_reg;
                a_nh_reg[i+1] <= s_nh_reg;
            end
        end
    end

    // final product by x, rounding to Q30, clamp, sign
    spr_ctl_t          fp_ctl_reg;
    pp_t               fp_pp_reg;
    logic              fp_sg_reg;
    logic              fp_nh_reg;
    spr_ctl_t          fs_ctl_reg;
    q_t                fs_m_reg;
    logic              fs_sn_reg;
    spr_ctl_t          fr_ctl_reg;
    logic [SINE_W-1:0] fr_v_reg;

    q_t          fs_m_next;
    logic [64:0] rnd_sum;
    logic [32:0] m30;
    logic [32:0] m30_sat;
    logic [SINE_W-1:0] v_next;

    assign fs_m_next = pp_sum(fp_pp_reg);
    assign rnd_sum   = {1'b0, fs_m_reg} + {1'b0, HALF_Q32};
    assign m30       = rnd_sum[64:32];
    assign m30_sat   = (m30 > ONE_Q30) ? ONE_Q30 : m30;
    assign v_next    = fs_sn_reg ? (SINE_W'(0) - m30_sat[SINE_W-1:0]) : m30_sat[SINE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_ctl_reg <= '0;
            fs_ctl_reg <= '0;
            fr_ctl_reg <= '0;
        end
        else if (adv)
        begin
            fp_ctl_reg <= a_ctl_reg[NUM_STEPS];
            fs_ctl_reg <= fp_ctl_reg;
            fr_ctl_reg <= fs_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fp_pp_reg <= pp_mul(a_m_reg[NUM_STEPS], a_x_reg[NUM_STEPS]);
            fp_sg_reg <= a_sg_reg[NUM_STEPS];
            fp_nh_reg <= a_nh_reg[NUM_STEPS];
            fs_m_reg  <= fs_m_next;
            fs_sn_reg <= (fp_sg_reg && (fs_m_next != '0)) ^ fp_nh_reg;
            fr_v_reg  <= v_next;
        end
    end

    assign ctl_o      = fr_ctl_reg;
    assign sine_value = fr_v_reg;

endmodule

// ----- hw/rtl/sine_poly_range_reduced.sv -----
// Top level of the fixed-point sine pipeline.
// One result per accepted transaction, in order, one transaction per cycle sustained while dout is ready.
// The angle (48-bit two's complement, 32 fractional bits) is reduced exactly modulo
// 2*pi, two bits per stage, folded into [0, pi/2], and run through an odd Taylor
// polynomial of 19 terms in Horner form; each 64-bit product takes a partial-product
// stage and a summing stage. A result passes through 86 register stages from
// acceptance to presentation: input capture, 24 reduction stages, sign and fold (2),
// x squared (2), three stages for each of the 18 Horner steps, and three for the
// final product, rounding and sign.
// The whole pipeline holds while a result waits on a deasserted ready; nothing is lost.
// sine_value is Q2.30, saturated to plus or minus 1; last_out follows last_in.
module sine_poly_range_reduced import spr_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    spr_in_if.sink   din,
    spr_out_if.source dout
);

    logic     adv;
    spr_ctl_t ctl_in;
    spr_ctl_t ctl_red;
    spr_ctl_t ctl_out;
    q_t       x;
    logic     neg_half;

    assign adv       = !ctl_out.valid || dout.ready;
    assign din.ready = adv;

    assign ctl_in.valid = din.valid;
    assign ctl_in.last  = din.last_in;

    spr_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_i    (ctl_in),
        .angle    (din.angle),
        .ctl_o    (ctl_red),
        .x        (x),
        .neg_half (neg_half)
    );

    spr_horner u_horner (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .ctl_i      (ctl_red),
        .x          (x),
        .neg_half   (neg_half),
        .ctl_o      (ctl_out),
        .sine_value (dout.sine_value)
    );

    assign dout.valid    = ctl_out.valid;
    assign dout.last_out = ctl_out.last;

endmodule

// ----- test/sine_poly_range_reduced_tb.sv -----
// Self-checking testbench for the pipelined fixed-point sine block.
module sine_poly_range_reduced_tb;
    import spr_pkg::*;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               last;
    } angle_txn_t;

    typedef struct packed {
        logic [SINE_W-1:0] sine;
        logic              last;
    } sine_txn_t;

    localparam int  LATENCY = 86;
    localparam longint MAX_CYCLES = 400000;

    logic clk;
    logic rst_n;

    spr_in_if  din ();
    spr_out_if dout ();

    sine_poly_range_reduced u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (din.sink),
        .dout (dout.source)
    );

    angle_txn_t angle_queue[$];
    sine_txn_t  sine_expected[$];
    int         error_count;
    longint     cycle_count;
    bit         no_idle;
    bit         hold_send;
    bit         in_taken;
    int         send_gap;
    int         recv_gap;
    logic [63:0] coef_mag [NUM_TERMS];

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // (a*b) >> 62 on unsigned magnitudes
    function automatic logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic signed [63:0] signed_q62_product(logic signed [63:0] a,
                                                             logic [63:0] b);
        logic [63:0] m;
        logic [63:0] p;
        m = a[63] ? -a : a;
        p = q62_product(m, b);
        return a[63] ? -$signed(p) : $signed(p);
    endfunction

    function automatic sine_txn_t predict_sine(angle_txn_t t);
        logic [47:0] mag;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] m;
        logic [63:0] m30;
        logic signed [63:0] acc;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [31:0] v;
        bit neg;
        bit neg_half;
        bit sn;
        sine_txn_t res;
        neg = t.angle[47];
        mag = neg ? -t.angle : t.angle;
        r = 0;
        for (int k = 47; k >= 0; k--)
        begin
            r = 2 * r + (mag[k] ? STEP : 64'd0);
            if (r >= TP) r = r - TP;
            if (r >= TP) r = r - TP;
        end
        if (neg && r != 0) r = TP - r;
        neg_half = r >= 2 * QP;
        if (r < QP) x = r;
        else if (r < 2 * QP) x = 2 * QP - r;
        else if (r < 3 * QP) x = r - 2 * QP;
        else x = TP - r;
        x = x << 2;
        x2 = q62_product(x, x);
        acc = ((NUM_TERMS - 1) % 2) ? -$signed(coef_mag[NUM_TERMS-1])
                                    : $signed(coef_mag[NUM_TERMS-1]);
        for (int k = NUM_TERMS - 2; k >= 0; k--)
        begin
            c = (k % 2) ? -$signed(coef_mag[k]) : $signed(coef_mag[k]);
            acc = signed_q62_product(acc, x2) + c;
        end
        s = signed_q62_product(acc, x);
        sn = s[63];
        m = sn ? -s : s;
        m30 = (m + HALF_Q32) >> 32;
        if (m30 > 64'(ONE_Q30)) m30 = 64'(ONE_Q30);
        if (neg_half) sn = !sn;
        v = sn ? -$signed(m30[31:0]) : $signed(m30[31:0]);
        res.sine = v;
        res.last = t.last;
        return res;
    endfunction

    function automatic logic [47:0] rad_to_fix(real a);
        return 48'(longint'(a * 4294967296.0));
    endfunction

    task automatic add_angle(logic [47:0] a, logic l);
        angle_txn_t t;
        t.angle = a;
        t.last = l;
        angle_queue.push_back(t);
    endtask

    // input acceptance
    always @(posedge clk)
    begin
        in_taken <= rst_n && din.valid && din.ready;
        if (rst_n && din.valid && din.ready)
            sine_expected.push_back(predict_sine({din.angle, din.last_in}));
    end

    // sender
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            din.valid   <= 1'b0;
            din.angle   <= '0;
            din.last_in <= 1'b0;
            send_gap    <= 0;
        end
        else
        begin
            if (!din.valid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    din.valid <= 1'b0;
                    send_gap  <= send_gap - 1;
                end
                else if (!no_idle && $urandom_range(0, 9) == 0)
                begin
                    din.valid <= 1'b0;
                    send_gap  <= $urandom_range(0, 10);
                end
                else if (angle_queue.size() > 0 && !hold_send)
                begin
                    angle_txn_t t;
                    t = angle_queue.pop_front();
                    din.valid   <= 1'b1;
                    din.angle   <= t.angle;
                    din.last_in <= t.last;
                end
                else
                    din.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout.ready <= 1'b0;
            recv_gap   <= 0;
        end
        else if (recv_gap > 0)
        begin
            dout.ready <= 1'b0;
            recv_gap   <= recv_gap - 1;
        end
        else if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            dout.ready <= 1'b0;
            recv_gap   <= $urandom_range(0, 10);
        end
        else
            dout.ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && dout.valid && dout.ready)
        begin
            if (sine_expected.size() == 0)
            begin
                $error("unexpected transaction: sine_value %0d", $signed(dout.sine_value));
                error_count++;
            end
            else
            begin
                sine_txn_t e;
                e = sine_expected.pop_front();
                if (dout.sine_value !== e.sine)
                begin
                    $error("sine_value expected %0d actual %0d",
                           $signed(e.sine), $signed(dout.sine_value));
                    error_count++;
                end
                if (dout.last_out !== e.last)
                begin
                    $error("last_out expected %0b actual %0b", e.last, dout.last_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        real pi;
        logic [47:0] a;
        int sel;
        pi = 3.14159265358979323846;
        error_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        hold_send = 1'b0;
        coef_mag[0] = ONE_Q62;
        for (int k = 1; k < NUM_TERMS; k++)
            coef_mag[k] = (coef_mag[k-1] + 64'((2*k)*(2*k+1)) / 2) / 64'((2*k)*(2*k+1));
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero, extremes, quadrant edges, overshoot region
        add_angle(48'd0, 1'b0);
        add_angle(48'h7FFF_FFFF_FFFF, 1'b1);
        add_angle(48'h8000_0000_0000, 1'b0);
        add_angle(48'hFFFF_FFFF_FFFF, 1'b1);
        add_angle(48'd1, 1'b0);
        add_angle(rad_to_fix(pi / 2), 1'b0);
        add_angle(rad_to_fix(pi / 2) + 1, 1'b0);
        add_angle(rad_to_fix(pi / 2) - 1, 1'b0);
        add_angle(rad_to_fix(3 * pi / 2), 1'b0);
        add_angle(rad_to_fix(pi), 1'b0);
        add_angle(rad_to_fix(2 * pi), 1'b0);
        add_angle(-rad_to_fix(pi / 2), 1'b1);
        add_angle(-rad_to_fix(3 * pi / 2), 1'b0);
        add_angle(-rad_to_fix(pi), 1'b0);
        add_angle(rad_to_fix(pi / 4), 1'b0);
        add_angle(-rad_to_fix(pi / 4), 1'b1);
        wait (angle_queue.size() == 0);
        // let the directed transactions drain before random traffic
        hold_send = 1'b1;
        wait (sine_expected.size() == 0 && !din.valid);
        repeat (LATENCY + 4) @(posedge clk);
        wait (sine_expected.size() == 0);
        hold_send = 1'b0;

        for (int i = 0; i < 1850; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                a = 48'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0003_FFFF) << 24;
            else if (sel < 6)
                a = rad_to_fix(pi / 2 * $urandom_range(0, 40) - 10 * pi)
                    + 48'($signed($urandom_range(0, 8)) - 4);
            else
                a = 48'({$urandom, $urandom});
            add_angle(a, 1'($urandom_range(0, 1)));
            if (i == 1500)
                no_idle = 1'b0;
        end
        wait (angle_queue.size() < 300);
        no_idle = 1'b1;
        wait (angle_queue.size() == 0);
        @(posedge clk);
        wait (!din.valid);
        wait (sine_expected.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0 && sine_expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/spr_pkg.sv
hw/rtl/spr_in_if.sv
hw/rtl/spr_out_if.sv
hw/rtl/spr_reduce.sv
hw/rtl/spr_horner.sv
hw/rtl/sine_poly_range_reduced.sv
test/sine_poly_range_reduced_tb.sv
